// ===== hdl/rrsm_pkg.sv =====
package rrsm_pkg;

  localparam int OUT_W = 24;
  localparam int SUM_W = 31;
  localparam int IN_W = 16;
  localparam int Q_W = 16;
  localparam int JOB_W = 6;
  localparam int ST_W = 5;

  typedef logic [OUT_W-1:0] out_time_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [IN_W-1:0] in_time_t;
  typedef logic [Q_W-1:0] quantum_t;
  typedef logic [JOB_W-1:0] job_t;
  typedef logic [ST_W-1:0] state_t;

  localparam quantum_t QUANTUM_RST = quantum_t'(4);

  localparam state_t S_LOAD  = 5'd0;
  localparam state_t S_RI    = 5'd1;
  localparam state_t S_RIW   = 5'd2;
  localparam state_t S_RJ    = 5'd3;
  localparam state_t S_RJW   = 5'd4;
  localparam state_t S_RW    = 5'd5;
  localparam state_t S_POP   = 5'd6;
  localparam state_t S_PW    = 5'd7;
  localparam state_t S_ID    = 5'd8;
  localparam state_t S_ID2   = 5'd9;
  localparam state_t S_RUN   = 5'd10;
  localparam state_t S_SCAN  = 5'd11;
  localparam state_t S_SCANW = 5'd12;
  localparam state_t S_REQ   = 5'd13;
  localparam state_t S_EREAD = 5'd14;
  localparam state_t S_ECALC = 5'd15;
  localparam state_t S_EOUT  = 5'd16;

endpackage

// ===== hdl/round_robin_schedule_metrics_top.sv =====
// Flow: items load one per cycle while in_ready is high; the last item starts a ranking
// pass that orders the jobs by arrival time, then round-robin time slices run, each one
// admitting newly arrived jobs to the ready queue; results then come out one job at a
// time, and the next result is computed only after the previous one is taken.
// Throughput: one job set at a time; the next set loads after its final result is taken.
// Reset (synchronous, active low) sets quantum to 4 and empties the job set.
module round_robin_schedule_metrics_top #(
  parameter int MAX_PROCS = 64,
  parameter int TIME_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  rrsm_pkg::quantum_t   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rrsm_pkg::in_time_t   in_arrival_time,
  input  rrsm_pkg::in_time_t   in_burst_time,
  input  logic                 in_last_job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rrsm_pkg::job_t       out_job_number,
  output rrsm_pkg::out_time_t  out_start_time,
  output rrsm_pkg::out_time_t  out_completion_time,
  output rrsm_pkg::out_time_t  out_turnaround,
  output rrsm_pkg::out_time_t  out_waiting,
  output rrsm_pkg::out_time_t  out_response,
  output rrsm_pkg::sum_t       out_total_turnaround,
  output rrsm_pkg::sum_t       out_total_waiting,
  output rrsm_pkg::sum_t       out_total_response,
  output rrsm_pkg::out_time_t  out_idle_time,
  output logic                 out_last_result
);
  import rrsm_pkg::*;

  localparam int IW = $clog2(MAX_PROCS);
  localparam int NW = $clog2(MAX_PROCS + 1);
  localparam int TW = TIME_BITS;
  localparam int CW = TIME_BITS + 8;

  logic [TW-1:0] arr_mem [MAX_PROCS];
  logic [TW-1:0] bur_mem [MAX_PROCS];
  logic [TW-1:0] rem_mem [MAX_PROCS];
  logic [CW-1:0] sta_mem [MAX_PROCS];
  logic [CW-1:0] cmp_mem [MAX_PROCS];
  logic [IW-1:0] ord_mem [MAX_PROCS];
  logic [TW-1:0] srt_mem [MAX_PROCS];
  logic [IW-1:0] fifo_mem [MAX_PROCS];

  logic [TW-1:0] arr_rd, bur_rd, rem_rd, srt_rd;
  logic [CW-1:0] sta_rd, cmp_rd;
  logic [IW-1:0] ord_rd, fifo_rd;
  logic [IW-1:0] arr_ra, rem_ra;

  state_t state_r;
  quantum_t quantum_r;
  logic [NW-1:0] n_r, i_r, j_r, cnt_r, k_r, next_pos_r, done_r, fcnt_r;
  logic [IW-1:0] head_r, tail_r, pos_r, id_r;
  logic [TW-1:0] ai_r;
  logic [CW-1:0] clock_r, idle_r;
  logic first_r, remnz_r;
  logic [MAX_PROCS-1:0] started_r;
  sum_t sum_tat_r, sum_wt_r, sum_rt_r;

  logic [CW-1:0] q_eff, arr_ext, st, rem_ext, tat, wt, rt;
  logic run_more, in_acc;
  logic [IW-1:0] slot;

  assign in_ready = (state_r == S_LOAD);
  assign in_acc = in_valid && in_ready;
  assign slot = n_r[IW-1:0];
  assign q_eff = (quantum_r == '0) ? CW'(1) : CW'(quantum_r);
  assign arr_ext = CW'(arr_rd);
  assign rem_ext = CW'(rem_rd);
  assign st = (started_r[id_r] || clock_r > arr_ext) ? clock_r : arr_ext;
  assign run_more = rem_ext > q_eff;
  assign tat = cmp_rd - arr_ext;
  assign wt = tat - CW'(bur_rd);
  assign rt = sta_rd - arr_ext;

  always_comb begin
    arr_ra = '0;
    rem_ra = '0;
    case (state_r)
      S_RI: arr_ra = i_r[IW-1:0];
      S_RJ: arr_ra = j_r[IW-1:0];
      S_ID2: begin
        arr_ra = ord_rd;
        rem_ra = ord_rd;
      end
      S_EREAD: arr_ra = k_r[IW-1:0];
      default: arr_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      arr_mem[slot] <= TW'(in_arrival_time);
      bur_mem[slot] <= TW'(in_burst_time);
    end
    arr_rd <= arr_mem[arr_ra];
    bur_rd <= bur_mem[k_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rem_mem[slot] <= TW'(in_burst_time);
    end else if (state_r == S_RUN) begin
      rem_mem[id_r] <= run_more ? TW'(rem_ext - q_eff) : '0;
    end
    rem_rd <= rem_mem[rem_ra];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RUN && !started_r[id_r]) begin
      sta_mem[id_r] <= st;
    end
    if (state_r == S_RUN && !run_more) begin
      cmp_mem[id_r] <= st + rem_ext;
    end
    sta_rd <= sta_mem[k_r[IW-1:0]];
    cmp_rd <= cmp_mem[k_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RW) begin
      ord_mem[cnt_r[IW-1:0]] <= i_r[IW-1:0];
      srt_mem[cnt_r[IW-1:0]] <= ai_r;
    end
    ord_rd <= ord_mem[pos_r];
    srt_rd <= srt_mem[next_pos_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SCANW && next_pos_r < n_r && CW'(srt_rd) <= clock_r) begin
      fifo_mem[tail_r] <= next_pos_r[IW-1:0];
    end else if (state_r == S_REQ && remnz_r) begin
      fifo_mem[tail_r] <= pos_r;
    end
    fifo_rd <= fifo_mem[head_r];
  end

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    wrap_inc = (v == IW'(MAX_PROCS - 1)) ? '0 : v + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      quantum_r <= QUANTUM_RST;
      n_r <= '0;
      out_valid <= 1'b0;
      started_r <= '0;
      fcnt_r <= '0;
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            n_r <= n_r + 1'b1;
            if (in_last_job || n_r == NW'(MAX_PROCS - 1)) begin
              i_r <= '0;
              state_r <= S_RI;
            end
          end
        end
        S_RI: state_r <= S_RIW;
        S_RIW: begin
          ai_r <= arr_rd;
          cnt_r <= '0;
          j_r <= '0;
          state_r <= S_RJ;
        end
        S_RJ: state_r <= S_RJW;
        S_RJW: begin
          if (arr_rd < ai_r || (arr_rd == ai_r && j_r < i_r)) begin
            cnt_r <= cnt_r + 1'b1;
          end
          j_r <= j_r + 1'b1;
          state_r <= (j_r + 1'b1 == n_r) ? S_RW : S_RJ;
        end
        S_RW: begin
          i_r <= i_r + 1'b1;
          if (i_r + 1'b1 == n_r) begin
            started_r <= '0;
            fcnt_r <= '0;
            head_r <= '0;
            tail_r <= '0;
            next_pos_r <= '0;
            done_r <= '0;
            clock_r <= '0;
            idle_r <= '0;
            first_r <= 1'b1;
            state_r <= S_POP;
          end else begin
            state_r <= S_RI;
          end
        end
        S_POP: begin
          if (fcnt_r == '0) begin
            pos_r <= next_pos_r[IW-1:0];
            next_pos_r <= next_pos_r + 1'b1;
            state_r <= S_ID;
          end else begin
            state_r <= S_PW;
          end
        end
        S_PW: begin
          pos_r <= fifo_rd;
          head_r <= wrap_inc(head_r);
          fcnt_r <= fcnt_r - 1'b1;
          state_r <= S_ID;
        end
        S_ID: state_r <= S_ID2;
        S_ID2: begin
          id_r <= ord_rd;
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (!first_r) begin
            idle_r <= idle_r + (st - clock_r);
          end
          first_r <= 1'b0;
          started_r[id_r] <= 1'b1;
          remnz_r <= run_more;
          if (run_more) begin
            clock_r <= st + q_eff;
          end else begin
            clock_r <= st + rem_ext;
            done_r <= done_r + 1'b1;
          end
          state_r <= S_SCAN;
        end
        S_SCAN: state_r <= (next_pos_r < n_r) ? S_SCANW : S_REQ;
        S_SCANW: begin
          if (CW'(srt_rd) <= clock_r) begin
            tail_r <= wrap_inc(tail_r);
            fcnt_r <= fcnt_r + 1'b1;
            next_pos_r <= next_pos_r + 1'b1;
            state_r <= S_SCAN;
          end else begin
            state_r <= S_REQ;
          end
        end
        S_REQ: begin
          if (remnz_r) begin
            tail_r <= wrap_inc(tail_r);
            fcnt_r <= fcnt_r + 1'b1;
          end
          if (done_r == n_r) begin
            k_r <= '0;
            sum_tat_r <= '0;
            sum_wt_r <= '0;
            sum_rt_r <= '0;
            state_r <= S_EREAD;
          end else begin
            state_r <= S_POP;
          end
        end
        S_EREAD: state_r <= S_ECALC;
        S_ECALC: begin
          out_job_number <= JOB_W'(k_r);
          out_start_time <= OUT_W'(sta_rd);
          out_completion_time <= OUT_W'(cmp_rd);
          out_turnaround <= OUT_W'(tat);
          out_waiting <= OUT_W'(wt);
          out_response <= OUT_W'(rt);
          out_total_turnaround <= sum_tat_r + SUM_W'(tat);
          out_total_waiting <= sum_wt_r + SUM_W'(wt);
          out_total_response <= sum_rt_r + SUM_W'(rt);
          sum_tat_r <= sum_tat_r + SUM_W'(tat);
          sum_wt_r <= sum_wt_r + SUM_W'(wt);
          sum_rt_r <= sum_rt_r + SUM_W'(rt);
          out_idle_time <= OUT_W'(idle_r);
          out_last_result <= (k_r + 1'b1 == n_r);
          out_valid <= 1'b1;
          state_r <= S_EOUT;
        end
        S_EOUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            k_r <= k_r + 1'b1;
            if (out_last_result) begin
              n_r <= '0;
              state_r <= S_LOAD;
            end else begin
              state_r <= S_EREAD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== hdl/rrsm_checker.sv =====
module rrsm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last_result,
  input rrsm_pkg::job_t out_job_number
);
  import rrsm_pkg::*;

  // The block never loads items while it is handing out results.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input accepted during result phase");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_job_number))
    else $error("result item dropped or changed while stalled");

  // After the final result is taken, the block returns to loading.
  a_last_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> in_ready)
    else $error("block did not return to loading after final result");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn before it was accepted");

endmodule

bind round_robin_schedule_metrics_top rrsm_checker u_rrsm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_last_result(out_last_result),
  .out_job_number(out_job_number)
);
